// File: src/slu_pkg.sv
`timescale 1ns / 1ps
// shared types, constants, saturation helper and microcode table of the lu solver
package slu_pkg;

    localparam int DEF_MAX_ORDER = 4;
    localparam int DEF_FRAC_BITS = 16;
    localparam int SOLVE_MAX     = 4;
    localparam int SCR_COLS      = SOLVE_MAX + 1;
    localparam logic [2:0] AUG_COL = 3'd4;

    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_SOLVE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SINGULAR = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] value;
    } slu_in_t;

    typedef struct packed {
        logic [1:0]         index;
        logic signed [31:0] solution;
        logic [1:0]         status;
        logic               last;
    } slu_out_t;

    typedef struct packed {
        logic done;
        logic sat;
    } div_rsp_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } sat_t;

    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        if (v > 64'sd2147483647) begin
            r.val = 32'sh7fffffff;
            r.sat = 1'b1;
        end else if (v < -64'sd2147483648) begin
            r.val = 32'sh80000000;
            r.sat = 1'b1;
        end else begin
            r.val = v[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    localparam int PC_W = 6;

    typedef enum logic [4:0] {
        OP_NOP    = 5'd0,
        OP_CPINIT = 5'd1,
        OP_CPRD   = 5'd2,
        OP_CPWR   = 5'd3,
        OP_UINIT  = 5'd4,
        OP_LD0    = 5'd5,
        OP_LDI    = 5'd6,
        OP_ACC    = 5'd7,
        OP_RD     = 5'd8,
        OP_MUL    = 5'd9,
        OP_SUB    = 5'd10,
        OP_TWR    = 5'd11,
        OP_PIV    = 5'd12,
        OP_PCHK   = 5'd13,
        OP_PVL    = 5'd14,
        OP_PVB    = 5'd15,
        OP_DST    = 5'd16,
        OP_DWRL   = 5'd17,
        OP_DWRB   = 5'd18,
        OP_KINC   = 5'd19,
        OP_BINIT  = 5'd20,
        OP_EINIT  = 5'd21,
        OP_ERD    = 5'd22,
        OP_EOUT   = 5'd23,
        OP_INCI   = 5'd24
    } op_t;

    typedef enum logic [3:0] {
        C_NONE   = 4'd0,
        C_ALWAYS = 4'd1,
        C_CPMORE = 4'd2,
        C_MGEK   = 4'd3,
        C_MGEN   = 4'd4,
        C_M1LTK  = 4'd5,
        C_M1LTN  = 4'd6,
        C_JLTN   = 4'd7,
        C_ZERO   = 4'd8,
        C_IGEN   = 4'd9,
        C_DBUSY  = 4'd10,
        C_K1LTN  = 4'd11,
        C_INZ    = 4'd12,
        C_OFULL  = 4'd13,
        C_I1LTN  = 4'd14
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uc_t;

    localparam logic [PC_W-1:0] P_IDLE   = 6'd0;
    localparam logic [PC_W-1:0] P_CPINIT = 6'd1;
    localparam logic [PC_W-1:0] P_CPRD   = 6'd2;
    localparam logic [PC_W-1:0] P_CPWR   = 6'd3;
    localparam logic [PC_W-1:0] P_UINIT  = 6'd4;
    localparam logic [PC_W-1:0] P_TLD    = 6'd5;
    localparam logic [PC_W-1:0] P_TACC   = 6'd6;
    localparam logic [PC_W-1:0] P_TRD    = 6'd7;
    localparam logic [PC_W-1:0] P_TMUL   = 6'd8;
    localparam logic [PC_W-1:0] P_TSUB   = 6'd9;
    localparam logic [PC_W-1:0] P_TWR    = 6'd10;
    localparam logic [PC_W-1:0] P_PIV    = 6'd11;
    localparam logic [PC_W-1:0] P_PCHK   = 6'd12;
    localparam logic [PC_W-1:0] P_LCHK   = 6'd13;
    localparam logic [PC_W-1:0] P_LLD    = 6'd14;
    localparam logic [PC_W-1:0] P_LACC   = 6'd15;
    localparam logic [PC_W-1:0] P_LRD    = 6'd16;
    localparam logic [PC_W-1:0] P_LMUL   = 6'd17;
    localparam logic [PC_W-1:0] P_LSUB   = 6'd18;
    localparam logic [PC_W-1:0] P_LDIV   = 6'd19;
    localparam logic [PC_W-1:0] P_LDST   = 6'd20;
    localparam logic [PC_W-1:0] P_LDWT   = 6'd21;
    localparam logic [PC_W-1:0] P_LWR    = 6'd22;
    localparam logic [PC_W-1:0] P_KNEXT  = 6'd23;
    localparam logic [PC_W-1:0] P_BINIT  = 6'd24;
    localparam logic [PC_W-1:0] P_BLD    = 6'd25;
    localparam logic [PC_W-1:0] P_BACC   = 6'd26;
    localparam logic [PC_W-1:0] P_BRD    = 6'd27;
    localparam logic [PC_W-1:0] P_BMUL   = 6'd28;
    localparam logic [PC_W-1:0] P_BSUB   = 6'd29;
    localparam logic [PC_W-1:0] P_BDIV   = 6'd30;
    localparam logic [PC_W-1:0] P_BDST   = 6'd31;
    localparam logic [PC_W-1:0] P_BDWT   = 6'd32;
    localparam logic [PC_W-1:0] P_BWR    = 6'd33;
    localparam logic [PC_W-1:0] P_EINIT  = 6'd34;
    localparam logic [PC_W-1:0] P_ERD    = 6'd35;
    localparam logic [PC_W-1:0] P_EOUT   = 6'd36;
    localparam logic [PC_W-1:0] P_ENEXT  = 6'd37;
    localparam logic [PC_W-1:0] P_EDONE  = 6'd38;

    // control store: copy, factor with forward pass on the augmented column,
    // back substitution, then emit
    function automatic uc_t ucode(input logic [PC_W-1:0] pc);
        uc_t w;
        case (pc)
            P_IDLE:   w = '{OP_NOP,    C_ALWAYS, P_IDLE};
            P_CPINIT: w = '{OP_CPINIT, C_NONE,   P_IDLE};
            P_CPRD:   w = '{OP_CPRD,   C_NONE,   P_IDLE};
            P_CPWR:   w = '{OP_CPWR,   C_CPMORE, P_CPRD};
            P_UINIT:  w = '{OP_UINIT,  C_NONE,   P_IDLE};
            P_TLD:    w = '{OP_LD0,    C_NONE,   P_IDLE};
            P_TACC:   w = '{OP_ACC,    C_MGEK,   P_TWR};
            P_TRD:    w = '{OP_RD,     C_NONE,   P_IDLE};
            P_TMUL:   w = '{OP_MUL,    C_NONE,   P_IDLE};
            P_TSUB:   w = '{OP_SUB,    C_M1LTK,  P_TRD};
            P_TWR:    w = '{OP_TWR,    C_JLTN,   P_TLD};
            P_PIV:    w = '{OP_PIV,    C_NONE,   P_IDLE};
            P_PCHK:   w = '{OP_PCHK,   C_ZERO,   P_EINIT};
            P_LCHK:   w = '{OP_NOP,    C_IGEN,   P_KNEXT};
            P_LLD:    w = '{OP_LD0,    C_NONE,   P_IDLE};
            P_LACC:   w = '{OP_ACC,    C_MGEK,   P_LDIV};
            P_LRD:    w = '{OP_RD,     C_NONE,   P_IDLE};
            P_LMUL:   w = '{OP_MUL,    C_NONE,   P_IDLE};
            P_LSUB:   w = '{OP_SUB,    C_M1LTK,  P_LRD};
            P_LDIV:   w = '{OP_PVL,    C_NONE,   P_IDLE};
            P_LDST:   w = '{OP_DST,    C_NONE,   P_IDLE};
            P_LDWT:   w = '{OP_NOP,    C_DBUSY,  P_LDWT};
            P_LWR:    w = '{OP_DWRL,   C_ALWAYS, P_LCHK};
            P_KNEXT:  w = '{OP_KINC,   C_K1LTN,  P_UINIT};
            P_BINIT:  w = '{OP_BINIT,  C_NONE,   P_IDLE};
            P_BLD:    w = '{OP_LDI,    C_NONE,   P_IDLE};
            P_BACC:   w = '{OP_ACC,    C_MGEN,   P_BDIV};
            P_BRD:    w = '{OP_RD,     C_NONE,   P_IDLE};
            P_BMUL:   w = '{OP_MUL,    C_NONE,   P_IDLE};
            P_BSUB:   w = '{OP_SUB,    C_M1LTN,  P_BRD};
            P_BDIV:   w = '{OP_PVB,    C_NONE,   P_IDLE};
            P_BDST:   w = '{OP_DST,    C_NONE,   P_IDLE};
            P_BDWT:   w = '{OP_NOP,    C_DBUSY,  P_BDWT};
            P_BWR:    w = '{OP_DWRB,   C_INZ,    P_BLD};
            P_EINIT:  w = '{OP_EINIT,  C_NONE,   P_IDLE};
            P_ERD:    w = '{OP_ERD,    C_NONE,   P_IDLE};
            P_EOUT:   w = '{OP_EOUT,   C_OFULL,  P_EOUT};
            P_ENEXT:  w = '{OP_INCI,   C_I1LTN,  P_ERD};
            P_EDONE:  w = '{OP_NOP,    C_ALWAYS, P_IDLE};
            default:  w = '{OP_NOP,    C_ALWAYS, P_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: src/small_lu_linear_solver.sv
`timescale 1ns / 1ps
// Solves A x = b for an order of 1 to 4 (ord_reg register, reset 4) by Doolittle LU
// without pivoting, in signed fixed point with FRAC_BITS fraction bits. Load items write one
// matrix or right-hand entry each. A solve item copies the stores into a scratch memory,
// factors with the right-hand side carried as an extra column, back-substitutes and then
// emits one item per unknown, the last marked; a zero pivot skips to the emit step with
// singular status. A small microprogram drives one multiplier and one bit-serial divider;
// the divider, run for each of the n(n-1)/2 + n quotients, sets most of the solve time,
// less at smaller orders. The input stalls from the solve until its last result sits in
// the output register.
module small_lu_linear_solver import slu_pkg::*; #(
    parameter int MAX_ORDER = DEF_MAX_ORDER,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  slu_in_t    in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output slu_out_t   out_data,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata
);

    localparam int SOLVE_LIMIT = (MAX_ORDER < SOLVE_MAX) ? MAX_ORDER : SOLVE_MAX;
    localparam int MDEPTH = MAX_ORDER * MAX_ORDER;
    localparam int MIDX_W = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
    localparam int RIDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    // configuration and sequencer
    logic [2:0]      ord_reg;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uc_t             uc;
    logic            cond_true;

    logic [2:0] i_reg;
    logic [2:0] j_reg;
    logic [2:0] k_reg;
    logic [2:0] m_reg;
    logic       sat_reg;
    logic       sing_reg;

    logic [2:0] n_act;
    logic [2:0] jcol;

    // load stores
    logic signed [31:0] mat_mem [MDEPTH];
    logic signed [31:0] rhs_mem [MAX_ORDER];
    logic [MDEPTH-1:0]    mv_reg;
    logic [MAX_ORDER-1:0] rv_reg;
    logic signed [31:0] sd_reg;

    logic in_acc;
    logic ld_a;
    logic ld_b;
    logic [MIDX_W-1:0] midx_wr;
    logic [RIDX_W-1:0] ridx_wr;
    logic [MIDX_W-1:0] midx_rd;
    logic [RIDX_W-1:0] ridx_rd;

    // scratch memory and datapath
    logic signed [31:0] scr_mem [SOLVE_MAX][SCR_COLS];
    logic               ra_en;
    logic [1:0]         ra_row;
    logic [2:0]         ra_col;
    logic               rb_en;
    logic [1:0]         rb_row;
    logic [2:0]         rb_col;
    logic               w_en;
    logic [1:0]         w_row;
    logic [2:0]         w_col;
    logic signed [31:0] w_data;
    logic signed [31:0] rd_a_reg;
    logic signed [31:0] rd_b_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] acc_reg;
    sat_t               term;
    sat_t               diff;

    logic signed [31:0] quo;
    div_rsp_t           drsp;

    logic       out_valid_reg;
    slu_out_t   out_reg;
    logic       out_free;

    assign in_acc  = in_valid & ~in_stall;
    assign ld_a    = in_acc && in_data.action == ACT_LOAD_A
                     && int'(in_data.row) < MAX_ORDER && int'(in_data.col) < MAX_ORDER;
    assign ld_b    = in_acc && in_data.action == ACT_LOAD_B && int'(in_data.row) < MAX_ORDER;
    assign midx_wr = MIDX_W'(int'(in_data.row) * MAX_ORDER + int'(in_data.col));
    assign ridx_wr = RIDX_W'(in_data.row);
    assign midx_rd = MIDX_W'(int'(i_reg) * MAX_ORDER + int'(j_reg));
    assign ridx_rd = RIDX_W'(i_reg);
    assign in_stall = (pc_reg != P_IDLE);
    assign out_free = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        if (ord_reg == 3'd0)
            n_act = 3'd1;
        else if (int'(ord_reg) > SOLVE_LIMIT)
            n_act = 3'(SOLVE_LIMIT);
        else
            n_act = ord_reg;
        // the right-hand side lives in the column after the last matrix column
        jcol = (j_reg == n_act) ? AUG_COL : j_reg;
        uc   = ucode(pc_reg);
    end

    always_comb
    begin
        case (uc.cond)
            C_NONE:   cond_true = 1'b0;
            C_ALWAYS: cond_true = 1'b1;
            C_CPMORE: cond_true = !(i_reg == n_act - 3'd1 && j_reg == n_act);
            C_MGEK:   cond_true = m_reg >= k_reg;
            C_MGEN:   cond_true = m_reg >= n_act;
            C_M1LTK:  cond_true = ({1'b0, m_reg} + 4'd1) < {1'b0, k_reg};
            C_M1LTN:  cond_true = ({1'b0, m_reg} + 4'd1) < {1'b0, n_act};
            C_JLTN:   cond_true = j_reg < n_act;
            C_ZERO:   cond_true = rd_a_reg == 32'sd0;
            C_IGEN:   cond_true = i_reg >= n_act;
            C_DBUSY:  cond_true = ~drsp.done;
            C_K1LTN:  cond_true = ({1'b0, k_reg} + 4'd1) < {1'b0, n_act};
            C_INZ:    cond_true = i_reg != 3'd0;
            C_OFULL:  cond_true = ~out_free;
            C_I1LTN:  cond_true = ({1'b0, i_reg} + 4'd1) < {1'b0, n_act};
            default:  cond_true = 1'b0;
        endcase

        if (pc_reg == P_IDLE && in_acc && in_data.action == ACT_SOLVE)
            pc_next = P_CPINIT;
        else if (cond_true)
            pc_next = uc.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    // scratch port selection
    always_comb
    begin
        ra_en  = 1'b0;
        ra_row = i_reg[1:0];
        ra_col = jcol;
        rb_en  = 1'b0;
        rb_row = m_reg[1:0];
        rb_col = jcol;
        w_en   = 1'b0;
        w_row  = i_reg[1:0];
        w_col  = jcol;
        w_data = acc_reg;
        case (uc.op)
            OP_LD0, OP_LDI: ra_en = 1'b1;
            OP_RD:
            begin
                ra_en  = 1'b1;
                ra_col = m_reg;
                rb_en  = 1'b1;
            end
            OP_PIV:
            begin
                ra_en  = 1'b1;
                ra_row = k_reg[1:0];
                ra_col = k_reg;
            end
            OP_PVL:
            begin
                rb_en  = 1'b1;
                rb_row = k_reg[1:0];
                rb_col = k_reg;
            end
            OP_PVB:
            begin
                rb_en  = 1'b1;
                rb_row = i_reg[1:0];
                rb_col = i_reg;
            end
            OP_ERD:
            begin
                ra_en  = 1'b1;
                ra_col = AUG_COL;
            end
            OP_CPWR:
            begin
                w_en   = 1'b1;
                w_data = sd_reg;
            end
            OP_TWR: w_en = 1'b1;
            OP_DWRL, OP_DWRB:
            begin
                w_en   = 1'b1;
                w_data = quo;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        term = sat32(prod_reg >>> FRAC_BITS);
        diff = sat32({{32{acc_reg[31]}}, acc_reg} - {{32{term.val[31]}}, term.val});
    end

    always_ff @(posedge clk)
    begin
        if (w_en)
            scr_mem[w_row][w_col] <= w_data;
        if (ra_en)
            rd_a_reg <= scr_mem[ra_row][ra_col];
        if (rb_en)
            rd_b_reg <= scr_mem[rb_row][rb_col];
        if (uc.op == OP_MUL)
            prod_reg <= rd_a_reg * rd_b_reg;
        if (uc.op == OP_ACC)
            acc_reg <= rd_a_reg;
        else if (uc.op == OP_SUB)
            acc_reg <= diff.val;
    end

    always_ff @(posedge clk)
    begin
        if (ld_a)
            mat_mem[midx_wr] <= in_data.value;
        if (ld_b)
            rhs_mem[ridx_wr] <= in_data.value;
        if (uc.op == OP_CPRD)
        begin
            if (j_reg == n_act)
                sd_reg <= rv_reg[ridx_rd] ? rhs_mem[ridx_rd] : 32'sd0;
            else
                sd_reg <= mv_reg[midx_rd] ? mat_mem[midx_rd] : 32'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= '0;
            rv_reg <= '0;
        end
        else
        begin
            if (ld_a)
                mv_reg[midx_wr] <= 1'b1;
            if (ld_b)
                rv_reg[ridx_wr] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ord_reg  <= 3'd4;
            pc_reg   <= P_IDLE;
            i_reg    <= '0;
            j_reg    <= '0;
            k_reg    <= '0;
            m_reg    <= '0;
            sat_reg  <= 1'b0;
            sing_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                ord_reg <= cfg_wdata;
            pc_reg <= pc_next;
            case (uc.op)
                OP_CPINIT:
                begin
                    i_reg    <= '0;
                    j_reg    <= '0;
                    k_reg    <= '0;
                    sat_reg  <= 1'b0;
                    sing_reg <= 1'b0;
                end
                OP_CPWR:
                begin
                    if (j_reg == n_act)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + 3'd1;
                    end
                    else
                        j_reg <= j_reg + 3'd1;
                end
                OP_UINIT:
                begin
                    i_reg <= k_reg;
                    j_reg <= k_reg;
                end
                OP_LD0: m_reg <= '0;
                OP_LDI: m_reg <= i_reg + 3'd1;
                OP_SUB:
                begin
                    m_reg   <= m_reg + 3'd1;
                    sat_reg <= sat_reg | term.sat | diff.sat;
                end
                OP_TWR:
                    if (j_reg < n_act)
                        j_reg <= j_reg + 3'd1;
                OP_PCHK:
                begin
                    sing_reg <= (rd_a_reg == 32'sd0);
                    i_reg    <= k_reg + 3'd1;
                    j_reg    <= k_reg;
                end
                OP_DWRL:
                begin
                    sat_reg <= sat_reg | drsp.sat;
                    i_reg   <= i_reg + 3'd1;
                end
                OP_DWRB:
                begin
                    sat_reg <= sat_reg | drsp.sat;
                    if (i_reg != 3'd0)
                        i_reg <= i_reg - 3'd1;
                end
                OP_KINC: k_reg <= k_reg + 3'd1;
                OP_BINIT:
                begin
                    i_reg <= n_act - 3'd1;
                    j_reg <= n_act;
                end
                OP_EINIT: i_reg <= '0;
                OP_INCI:  i_reg <= i_reg + 3'd1;
                default: ;
            endcase
        end
    end

    slu_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (uc.op == OP_DST),
        .dividend (acc_reg),
        .divisor  (rd_b_reg),
        .quotient (quo),
        .rsp      (drsp)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (uc.op == OP_EOUT && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (uc.op == OP_EOUT && out_free)
        begin
            out_reg.index    <= i_reg[1:0];
            out_reg.solution <= sing_reg ? 32'sd0 : rd_a_reg;
            out_reg.status   <= sing_reg ? ST_SINGULAR : (sat_reg ? ST_SAT : ST_OK);
            out_reg.last     <= (i_reg == n_act - 3'd1);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: src/slu_div.sv
`timescale 1ns / 1ps
// bit-serial signed fixed point divider with saturation
module slu_div import slu_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] dividend,
    input  logic signed [31:0] divisor,
    output logic signed [31:0] quotient,
    output div_rsp_t           rsp
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   dmag_reg;
    logic          neg_reg;
    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic          sat_reg;
    logic signed [31:0] quo_reg;

    logic [32:0]   rem_sh;
    logic          ge;
    logic [32:0]   rem_sub;
    logic [NW-1:0] num_next;
    logic [31:0]   amag;
    logic          hi_nz;
    logic          sat_next;

    always_comb
    begin
        amag     = dividend[31] ? 32'(-dividend) : 32'(dividend);
        rem_sh   = {rem_reg, num_reg[NW-1]};
        ge       = rem_sh >= {1'b0, dmag_reg};
        rem_sub  = rem_sh - {1'b0, dmag_reg};
        num_next = {num_reg[NW-2:0], ge};
        hi_nz    = |num_next[NW-1:32];
        // negative side may reach one more than the positive side
        sat_next = neg_reg ? (hi_nz | (num_next[31] & (|num_next[30:0])))
                           : (hi_nz | num_next[31]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= {amag, {FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            dmag_reg <= divisor[31] ? 32'(-divisor) : 32'(divisor);
            neg_reg  <= dividend[31] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
            if (cnt_reg == CW'(1))
            begin
                sat_reg <= sat_next;
                if (sat_next)
                    quo_reg <= neg_reg ? 32'sh80000000 : 32'sh7fffffff;
                else
                    quo_reg <= neg_reg ? 32'(-num_next[31:0]) : num_next[31:0];
            end
        end
    end

    assign quotient = quo_reg;
    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;

endmodule

// File: src/slu_chk.sv
`timescale 1ns / 1ps
// port checker for the lu solver and its binding
module slu_chk import slu_pkg::*; (
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input slu_in_t  in_data,
    input logic     out_valid,
    input logic     out_stall,
    input slu_out_t out_data
);

    // a held result item keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_SINGULAR |-> out_data.solution == 32'sd0)
        else $error("singular result with non-zero solution");

    a_idx_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.index == 2'd3 |-> out_data.last)
        else $error("fourth unknown not marked last");

    a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.action == ACT_SOLVE |=> in_stall)
        else $error("input taken right after a solve item");

endmodule

bind small_lu_linear_solver slu_chk u_slu_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// File: sim/tb.sv
`timescale 1ns / 1ps
// testbench of the lu linear solver: directed and random loads and solves checked against a predictor
module tb;
    import slu_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    slu_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    slu_out_t out_data;
    logic     cfg_we;
    logic [2:0] cfg_wdata;

    small_lu_linear_solver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic signed [31:0] mat_q [4][4];
    logic signed [31:0] rhs_q [4];
    logic [2:0]         order_q;
    bit                 sat_seen;
    slu_out_t           solution_queue [$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int results_seen;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic signed [31:0] clip(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            sat_seen = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            sat_seen = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] d;
        d = 64'(a) - 64'(b);
        return clip(d);
    endfunction

    // arithmetic shift floors toward minus infinity
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return clip(p >>> 16);
    endfunction

    function automatic logic signed [31:0] qdiv(input logic signed [31:0] a,
                                                input logic signed [31:0] d);
        logic signed [63:0] num;
        num = 64'(a) <<< 16;
        return clip(num / 64'(d));
    endfunction

    task automatic predict_solution();
        logic signed [31:0] lo [4][4];
        logic signed [31:0] up [4][4];
        logic signed [31:0] y [4];
        logic signed [31:0] x [4];
        logic signed [31:0] s;
        bit       singular;
        int       n;
        logic [1:0] st;
        slu_out_t r;
        n = order_q;
        if (n < 1) n = 1;
        if (n > 4) n = 4;
        singular = 1'b0;
        sat_seen = 1'b0;
        for (int a = 0; a < 4; a++)
        begin
            x[a] = '0;
            y[a] = '0;
            for (int b = 0; b < 4; b++)
            begin
                lo[a][b] = '0;
                up[a][b] = '0;
            end
        end
        for (int k = 0; k < n && !singular; k++)
        begin
            for (int j = k; j < n; j++)
            begin
                s = mat_q[k][j];
                for (int m = 0; m < k; m++) s = qsub(s, qmul(lo[k][m], up[m][j]));
                up[k][j] = s;
            end
            if (up[k][k] == 0)
                singular = 1'b1;
            else
                for (int i = k + 1; i < n; i++)
                begin
                    s = mat_q[i][k];
                    for (int m = 0; m < k; m++) s = qsub(s, qmul(lo[i][m], up[m][k]));
                    lo[i][k] = qdiv(s, up[k][k]);
                end
        end
        if (!singular)
        begin
            for (int i = 0; i < n; i++)
            begin
                s = rhs_q[i];
                for (int m = 0; m < i; m++) s = qsub(s, qmul(lo[i][m], y[m]));
                y[i] = s;
            end
            for (int i = n - 1; i >= 0; i--)
            begin
                s = y[i];
                for (int m = i + 1; m < n; m++) s = qsub(s, qmul(up[i][m], x[m]));
                x[i] = qdiv(s, up[i][i]);
            end
        end
        st = singular ? ST_SINGULAR : (sat_seen ? ST_SAT : ST_OK);
        for (int i = 0; i < n; i++)
        begin
            r.index    = 2'(i);
            r.solution = singular ? 32'sd0 : x[i];
            r.status   = st;
            r.last     = (i == n - 1);
            solution_queue.push_back(r);
        end
    endtask

    // valid stays high after the item so a following item can go back to back
    task automatic send_item(input logic [1:0] action, input logic [1:0] row,
                             input logic [1:0] col, input logic [31:0] value);
        slu_in_t it;
        it.action = action;
        it.row    = row;
        it.col    = col;
        it.value  = value;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        case (action)
            ACT_LOAD_A: mat_q[row][col] = value;
            ACT_LOAD_B: rhs_q[row] = value;
            ACT_SOLVE:  predict_solution();
            default:    ;
        endcase
        @(negedge clk);
    endtask

    // wait for every result, then let the engine settle before a register write
    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (solution_queue.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (20) @(negedge clk);
    endtask

    task automatic set_order(input logic [2:0] n);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(negedge clk);
        cfg_we    <= 1'b0;
        order_q = n;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(8)) - 4) <<< 16;
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            3: return 32'h0;
            default: return 32'($signed($urandom_range(262143)) - 131072) <<< 2;
        endcase
    endfunction

    task automatic load_system(input int n, input bit diag_dom);
        logic [31:0] v;
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < n; c++)
            begin
                v = rand_value();
                if (diag_dom)
                    v = (r == c) ? 32'($signed($urandom_range(6)) + 2) <<< 16
                                 : 32'($signed($urandom_range(65535)) - 32768);
                send_item(ACT_LOAD_A, 2'(r), 2'(c), v);
            end
            send_item(ACT_LOAD_B, 2'(r), 2'($urandom), rand_value());
        end
    endtask

    task automatic test_directed();
        // cleared stores: zero pivot at default order
        send_item(ACT_SOLVE, 2'd0, 2'd0, 32'h0);
        // identity with extreme right-hand side
        for (int r = 0; r < 4; r++)
            send_item(ACT_LOAD_A, 2'(r), 2'(r), 32'h0001_0000);
        send_item(ACT_LOAD_B, 2'd0, 2'd3, 32'h7fffffff);
        send_item(ACT_LOAD_B, 2'd1, 2'd0, 32'h80000000);
        send_item(ACT_LOAD_B, 2'd2, 2'd0, 32'hffffffff);
        send_item(ACT_LOAD_B, 2'd3, 2'd0, 32'h0000_0001);
        send_item(ACT_SOLVE, 2'd3, 2'd3, 32'hffffffff);
        // unused action is ignored
        send_item(2'd3, 2'd1, 2'd1, 32'h5555_aaaa);
        // tiny pivot forces saturation on the quotient
        send_item(ACT_LOAD_A, 2'd0, 2'd0, 32'h0000_0001);
        send_item(ACT_SOLVE, 2'd0, 2'd0, 32'h0);
        send_item(ACT_LOAD_A, 2'd0, 2'd0, 32'h8000_0000);
        send_item(ACT_LOAD_A, 2'd3, 2'd3, 32'h7fff_ffff);
        send_item(ACT_SOLVE, 2'd0, 2'd0, 32'h0);
    endtask

    task automatic test_orders();
        logic [2:0] orders [6] = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4};
        foreach (orders[o])
        begin
            set_order(orders[o]);
            load_system(4, 1'b1);
            send_item(ACT_SOLVE, 2'd0, 2'd0, 32'h0);
        end
    endtask

    task automatic test_random(input int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items)
        begin
            n = order_q == 0 ? 1 : (order_q > 4 ? 4 : order_q);
            if ($urandom_range(3) != 0)
            begin
                load_system(n, $urandom_range(2) != 0);
                sent += n * (n + 1);
            end
            else
                repeat ($urandom_range(4) + 1)
                begin
                    send_item(2'($urandom), 2'($urandom), 2'($urandom), rand_value());
                    sent++;
                end
            send_item(ACT_SOLVE, 2'($urandom), 2'($urandom), $urandom);
            sent++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        slu_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (solution_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected result %p", out_data);
            end
            else
            begin
                want = solution_queue.pop_front();
                if (out_data.index !== want.index || out_data.solution !== want.solution ||
                    out_data.status !== want.status || out_data.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: mismatch expected %p got %p", want, out_data);
                end
            end
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    initial
    begin
        #200_000_000;
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        int pct [4][2] = '{'{0, 0}, '{46, 0}, '{0, 46}, '{26, 26}};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        results_seen = 0;
        order_q = 3'd4;
        for (int a = 0; a < 4; a++)
        begin
            rhs_q[a] = '0;
            for (int b = 0; b < 4; b++) mat_q[a][b] = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_orders();
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = pct[p][0];
            recv_stall_pct = pct[p][1];
            // hold the sender until everything is out
            drain();
            set_order(3'($urandom_range(4) + 1));
            test_random(60);
        end
        recv_stall_pct = 0;
        drain();
        repeat (100) @(negedge clk);
        if (mismatches == 0 && solution_queue.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

// File: filelist.f
src/slu_pkg.sv
src/slu_div.sv
src/small_lu_linear_solver.sv
src/slu_chk.sv
sim/tb.sv
